// ----- src/fsds_pkg.sv -----
// ----------------------------------------------------------------------------
// fsds_pkg: shared types and constants of the feed snapshot/diff sequencer
// Holds the event, link state and result kind codes, the sizes of the
// stream payloads and the result type of the shared compare unit.
// ----------------------------------------------------------------------------
package fsds_pkg;

	localparam int IdBits  = 64;
	localparam int TagBits = 16;
	localparam int CntBits = 32;

	localparam int BufferDepthDefault = 32;
	localparam int TagWidthDefault    = 16;

	// Input stream: tdata carries first, last, prev, snapshot id and tag.
	localparam int InDataBits = 4 * IdBits + TagBits;
	localparam int InDataPad  = ((InDataBits + 7) / 8) * 8;
	localparam int InUserBits = 2;

	// Output stream: tdata carries state, first, last, prev, tag, resync total.
	localparam int OutDataBits = 3 + 3 * IdBits + TagBits + CntBits;
	localparam int OutDataPad  = ((OutDataBits + 7) / 8) * 8;
	localparam int OutUserBits = 3;

	typedef enum logic [1:0] {
		CMD_DIFF       = 2'd0,
		CMD_CONNECT    = 2'd1,
		CMD_DISCONNECT = 2'd2,
		CMD_SNAPSHOT   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		LK_DISC   = 3'd0,
		LK_BUF    = 3'd1,
		LK_AWAIT  = 3'd2,
		LK_SYNC   = 3'd3,
		LK_RESYNC = 3'd4
	} link_t;

	typedef enum logic [2:0] {
		K_DROP     = 3'd0,
		K_BUFFERED = 3'd1,
		K_APPLY    = 3'd2,
		K_RESYNC   = 3'd3,
		K_DRAIN    = 3'd4,
		K_DONE     = 3'd5,
		K_FULL     = 3'd6
	} kind_t;

	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_EXEC,
		SQ_AW_LO,
		SQ_AW_HI,
		SQ_SCAN,
		SQ_CHK_LO,
		SQ_CHK_HI,
		SQ_DRAIN,
		SQ_FIN
	} seq_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

endpackage

// ----- src/fsds_ram.sv -----
// ----------------------------------------------------------------------------
// fsds_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fsds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ----- src/fsds_cmp.sv -----
// ----------------------------------------------------------------------------
// fsds_cmp: shared id comparator
// Unsigned less-than and equality of two update ids; every id decision of
// the sequencer goes through this one unit.
// ----------------------------------------------------------------------------
module fsds_cmp (
	input  logic [fsds_pkg::IdBits-1:0] op_a,
	input  logic [fsds_pkg::IdBits-1:0] op_b,
	output fsds_pkg::cmp_res_t          res
);

	import fsds_pkg::*;

	always_comb begin
		res.lt = (op_a < op_b);
		res.eq = (op_a == op_b);
	end

endmodule

// ----- src/feed_snapshot_diff_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// feed_snapshot_diff_sequencer_unit: snapshot/diff sync sequencer
// Keeps a market-data diff stream in step with an order-book snapshot.
// ----------------------------------------------------------------------------
// One event is taken per transfer and answered with one or more result
// transfers, the final one marked by tlast. Every id comparison runs through
// a single 64-bit comparator, one comparison per cycle, and buffered diffs
// sit in one RAM with a registered read port. Connect, disconnect and diffs
// while disconnected, buffering, resyncing or synced are accepted, then run
// in one execute step; a diff while awaiting the snapshot may also go on to
// a low and a high span check. A snapshot passes through accept and decode,
// a scan for the first live entry, two span checks, a drain over the rest
// and the closing result, one buffer entry per cycle unless a live entry
// waits for the output register; without a live entry it goes straight to
// the closing result, and an ignored one is dropped. A new event is accepted
// in the cycle after the last result of the previous one has entered the
// output register, even while that result still waits to be taken; the
// sequencer stalls when it has a result ready and the output register is full.
// ----------------------------------------------------------------------------
module feed_snapshot_diff_sequencer_unit #(
	parameter int BUFFER_DEPTH = fsds_pkg::BufferDepthDefault,
	parameter int TAG_WIDTH    = fsds_pkg::TagWidthDefault
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// first id, last id, prev id, snapshot id, update tag (lowest bit up)
	input  logic [fsds_pkg::InDataPad-1:0]   s_tdata,
	// cmd
	input  logic [fsds_pkg::InUserBits-1:0]  s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// state, first id, last id, prev id, tag, resync total, zero fill
	// (lowest bit up)
	output logic [fsds_pkg::OutDataPad-1:0]  m_tdata,
	// kind
	output logic [fsds_pkg::OutUserBits-1:0] m_tuser,
	// last_of_run
	output logic                             m_tlast
);

	import fsds_pkg::*;

	localparam int AW      = $clog2(BUFFER_DEPTH);
	localparam int CW      = $clog2(BUFFER_DEPTH + 1);
	localparam int TK      = (TAG_WIDTH < TagBits) ? TAG_WIDTH : TagBits;
	localparam int RAM_W   = 3 * IdBits + TK;
	localparam int OFS_LA  = IdBits;
	localparam int OFS_PR  = 2 * IdBits;
	localparam int OFS_TAG = 3 * IdBits;

	// Captured event
	cmd_t                cmd_q;
	logic [IdBits-1:0]   fi_q, la_q, pr_q, sn_q;
	logic [TK-1:0]       tag_q;

	// Sequencer and link state
	seq_t                seq_q, seq_d;
	link_t               fsm_q, fsm_d, fin_q, fin_d;
	logic [CW-1:0]       count_q, count_d, idx_q, idx_d;
	logic [IdBits-1:0]   snap_q, snap_d, snap1_q, snap1_d, applied_q, applied_d;
	logic [CntBits-1:0]  resync_q, resync_d;

	// Output register
	logic                out_valid_q;
	kind_t               out_kind_q;
	link_t               out_state_q;
	logic [IdBits-1:0]   out_fi_q, out_la_q, out_pr_q;
	logic [TagBits-1:0]  out_tag_q;
	logic [CntBits-1:0]  out_total_q;
	logic                out_last_q;

	// Result being produced this cycle
	logic                emit;
	kind_t               e_kind;
	link_t               e_state;
	logic [IdBits-1:0]   e_fi, e_la, e_pr;
	logic [TagBits-1:0]  e_tag;
	logic [CntBits-1:0]  e_total;
	logic                e_last;

	logic                out_free;
	logic                accept;

	// Buffer RAM
	logic                wr_en;
	logic [RAM_W-1:0]    wr_data, rd_data;
	logic [IdBits-1:0]   rd_fi, rd_la, rd_pr;
	logic [TK-1:0]       rd_tag;

	// Shared comparator
	logic [IdBits-1:0]   op_a, op_b;
	cmp_res_t            cmp;

	logic [CW-1:0]       idx_inc;
	logic                idx_end;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (seq_q == SQ_IDLE);
	assign out_free = !out_valid_q || m_tready;

	assign rd_fi  = rd_data[OFS_LA-1:0];
	assign rd_la  = rd_data[OFS_PR-1:OFS_LA];
	assign rd_pr  = rd_data[OFS_TAG-1:OFS_PR];
	assign rd_tag = rd_data[RAM_W-1:OFS_TAG];

	assign wr_data = {tag_q, pr_q, la_q, fi_q};
	assign idx_inc = idx_q + CW'(1);
	assign idx_end = (idx_inc == count_q);

	fsds_ram #(
		.WIDTH (RAM_W),
		.DEPTH (BUFFER_DEPTH)
	) u_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (wr_data),
		.rd_addr (idx_d[AW-1:0]),
		.rd_data (rd_data)
	);

	fsds_cmp u_cmp (
		.op_a (op_a),
		.op_b (op_b),
		.res  (cmp)
	);

	// Operand selection for the comparator
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (seq_q)
			SQ_EXEC: begin
				if (fsm_q == LK_SYNC) begin
					op_a = pr_q;
					op_b = applied_q;
				end else begin
					op_a = snap_q;
					op_b = la_q;
				end
			end
			SQ_AW_LO: begin
				op_a = snap1_q;
				op_b = fi_q;
			end
			SQ_AW_HI: begin
				op_a = la_q;
				op_b = snap1_q;
			end
			SQ_SCAN, SQ_DRAIN: begin
				op_a = snap_q;
				op_b = rd_la;
			end
			SQ_CHK_LO: begin
				op_a = snap1_q;
				op_b = rd_fi;
			end
			SQ_CHK_HI: begin
				op_a = rd_la;
				op_b = snap1_q;
			end
			SQ_IDLE, SQ_FIN: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Sequencer: next state, state updates and the result of this cycle
	always_comb begin
		seq_d     = seq_q;
		fsm_d     = fsm_q;
		fin_d     = fin_q;
		count_d   = count_q;
		idx_d     = idx_q;
		snap_d    = snap_q;
		snap1_d   = snap1_q;
		applied_d = applied_q;
		resync_d  = resync_q;
		wr_en     = 1'b0;
		emit      = 1'b0;
		e_kind    = K_DROP;
		e_state   = fsm_q;
		e_fi      = '0;
		e_la      = '0;
		e_pr      = '0;
		e_tag     = '0;
		e_total   = resync_q;
		e_last    = 1'b1;

		unique case (seq_q)
			SQ_IDLE: begin
				if (accept) begin
					seq_d = SQ_EXEC;
				end
			end
			SQ_EXEC: begin
				unique case (cmd_q)
					CMD_CONNECT: begin
						if (out_free) begin
							emit      = 1'b1;
							e_kind    = K_DONE;
							e_state   = LK_BUF;
							count_d   = '0;
							snap_d    = '0;
							snap1_d   = IdBits'(1);
							applied_d = '0;
							fsm_d     = LK_BUF;
							seq_d     = SQ_IDLE;
						end
					end
					CMD_DISCONNECT: begin
						if (out_free) begin
							emit    = 1'b1;
							e_kind  = K_DONE;
							e_state = LK_DISC;
							count_d = '0;
							fsm_d   = LK_DISC;
							seq_d   = SQ_IDLE;
						end
					end
					CMD_SNAPSHOT: begin
						if (fsm_q == LK_BUF || fsm_q == LK_AWAIT) begin
							snap_d  = sn_q;
							snap1_d = sn_q + IdBits'(1);
							idx_d   = '0;
							if (count_q == '0) begin
								fin_d = LK_AWAIT;
								seq_d = SQ_FIN;
							end else begin
								seq_d = SQ_SCAN;
							end
						end else if (out_free) begin
							emit   = 1'b1;
							e_kind = K_DROP;
							seq_d  = SQ_IDLE;
						end
					end
					CMD_DIFF: begin
						if (out_free) begin
							unique case (fsm_q)
								LK_BUF: begin
									emit  = 1'b1;
									seq_d = SQ_IDLE;
									if (count_q < CW'(BUFFER_DEPTH)) begin
										wr_en   = 1'b1;
										count_d = count_q + CW'(1);
										e_kind  = K_BUFFERED;
									end else begin
										e_kind = K_FULL;
									end
								end
								LK_AWAIT: begin
									// Stale unless the snapshot id is below last_id.
									if (!cmp.lt) begin
										emit   = 1'b1;
										e_kind = K_DROP;
										seq_d  = SQ_IDLE;
									end else begin
										emit  = 1'b0;
										seq_d = SQ_AW_LO;
									end
								end
								LK_SYNC: begin
									emit  = 1'b1;
									seq_d = SQ_IDLE;
									if (!cmp.eq) begin
										e_kind   = K_RESYNC;
										e_state  = LK_RESYNC;
										e_total  = resync_q + CntBits'(1);
										resync_d = resync_q + CntBits'(1);
										fsm_d    = LK_RESYNC;
										count_d  = '0;
									end else begin
										e_kind    = K_APPLY;
										e_fi      = fi_q;
										e_la      = la_q;
										e_pr      = pr_q;
										e_tag     = TagBits'(tag_q);
										applied_d = la_q;
									end
								end
								default: begin
									emit   = 1'b1;
									e_kind = K_DROP;
									seq_d  = SQ_IDLE;
								end
							endcase
						end
					end
				endcase
			end
			SQ_AW_LO: begin
				if (!cmp.lt) begin
					seq_d = SQ_AW_HI;
				end else if (out_free) begin
					emit     = 1'b1;
					e_kind   = K_RESYNC;
					e_state  = LK_RESYNC;
					e_total  = resync_q + CntBits'(1);
					resync_d = resync_q + CntBits'(1);
					fsm_d    = LK_RESYNC;
					count_d  = '0;
					seq_d    = SQ_IDLE;
				end
			end
			SQ_AW_HI: begin
				if (out_free) begin
					emit  = 1'b1;
					seq_d = SQ_IDLE;
					if (cmp.lt) begin
						e_kind   = K_RESYNC;
						e_state  = LK_RESYNC;
						e_total  = resync_q + CntBits'(1);
						resync_d = resync_q + CntBits'(1);
						fsm_d    = LK_RESYNC;
						count_d  = '0;
					end else begin
						e_kind    = K_APPLY;
						e_state   = LK_SYNC;
						e_fi      = fi_q;
						e_la      = la_q;
						e_pr      = pr_q;
						e_tag     = TagBits'(tag_q);
						applied_d = la_q;
						fsm_d     = LK_SYNC;
					end
				end
			end
			SQ_SCAN: begin
				// The read data always belongs to the entry at idx_q.
				if (cmp.lt) begin
					seq_d = SQ_CHK_LO;
				end else if (idx_end) begin
					fin_d = LK_AWAIT;
					seq_d = SQ_FIN;
				end else begin
					idx_d = idx_inc;
				end
			end
			SQ_CHK_LO: begin
				if (!cmp.lt) begin
					seq_d = SQ_CHK_HI;
				end else if (out_free) begin
					emit     = 1'b1;
					e_kind   = K_RESYNC;
					e_state  = LK_RESYNC;
					e_total  = resync_q + CntBits'(1);
					resync_d = resync_q + CntBits'(1);
					fsm_d    = LK_RESYNC;
					count_d  = '0;
					seq_d    = SQ_IDLE;
				end
			end
			SQ_CHK_HI: begin
				if (!cmp.lt) begin
					seq_d = SQ_DRAIN;
				end else if (out_free) begin
					emit     = 1'b1;
					e_kind   = K_RESYNC;
					e_state  = LK_RESYNC;
					e_total  = resync_q + CntBits'(1);
					resync_d = resync_q + CntBits'(1);
					fsm_d    = LK_RESYNC;
					count_d  = '0;
					seq_d    = SQ_IDLE;
				end
			end
			SQ_DRAIN: begin
				// Live entries are handed out; stale ones are skipped in place.
				if (!cmp.lt || out_free) begin
					if (cmp.lt) begin
						emit      = 1'b1;
						e_kind    = K_DRAIN;
						e_state   = LK_SYNC;
						e_fi      = rd_fi;
						e_la      = rd_la;
						e_pr      = rd_pr;
						e_tag     = TagBits'(rd_tag);
						e_last    = 1'b0;
						applied_d = rd_la;
					end
					if (idx_end) begin
						fin_d = LK_SYNC;
						seq_d = SQ_FIN;
					end else begin
						idx_d = idx_inc;
					end
				end
			end
			SQ_FIN: begin
				if (out_free) begin
					emit    = 1'b1;
					e_kind  = K_DONE;
					e_state = fin_q;
					fsm_d   = fin_q;
					count_d = '0;
					seq_d   = SQ_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= SQ_IDLE;
			fsm_q       <= LK_DISC;
			fin_q       <= LK_AWAIT;
			count_q     <= '0;
			idx_q       <= '0;
			snap_q      <= '0;
			snap1_q     <= IdBits'(1);
			applied_q   <= '0;
			resync_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			seq_q     <= seq_d;
			fsm_q     <= fsm_d;
			fin_q     <= fin_d;
			count_q   <= count_d;
			idx_q     <= idx_d;
			snap_q    <= snap_d;
			snap1_q   <= snap1_d;
			applied_q <= applied_d;
			resync_q  <= resync_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(s_tuser);
			fi_q  <= s_tdata[IdBits-1:0];
			la_q  <= s_tdata[2*IdBits-1:IdBits];
			pr_q  <= s_tdata[3*IdBits-1:2*IdBits];
			sn_q  <= s_tdata[4*IdBits-1:3*IdBits];
			tag_q <= s_tdata[4*IdBits+TK-1:4*IdBits];
		end
		if (emit) begin
			out_kind_q  <= e_kind;
			out_state_q <= e_state;
			out_fi_q    <= e_fi;
			out_la_q    <= e_la;
			out_pr_q    <= e_pr;
			out_tag_q   <= e_tag;
			out_total_q <= e_total;
			out_last_q  <= e_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = OutDataPad'({out_total_q, out_tag_q, out_pr_q, out_la_q, out_fi_q,
		out_state_q});

	// The buffer never holds more entries than its depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(BUFFER_DEPTH))
		else $error("buffer count beyond depth");

	// Scan and drain only visit entries that are held.
	assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == SQ_SCAN || seq_q == SQ_DRAIN) |-> (idx_q < count_q))
		else $error("buffer index past fill count");

	// The input is never ready right after it has accepted an event.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input reopened during a step");

	// Drained entries are never the closing result and report the synced state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && e_kind == K_DRAIN) |-> (!e_last && e_state == LK_SYNC))
		else $error("drained entry with wrong state or run mark");

	// Every resync adds exactly one to the counter.
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && e_kind == K_RESYNC) |=> (resync_q == $past(resync_q) + CntBits'(1)))
		else $error("resync not counted");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the feed snapshot/diff sequencer
// Events are queued up front and driven by a clocked driver; a predictor of
// the sequencer works out the result transfers of each accepted event, and a
// clocked monitor compares every result transfer with the oldest one waiting.
// ----------------------------------------------------------------------------
module tb_top;

	import fsds_pkg::*;

	localparam int Depth    = BufferDepthDefault;
	localparam int WdLimit  = 5000;
	localparam int ItemGoal = 110;

	typedef struct {
		cmd_t         cmd;
		logic [63:0]  head_id;
		logic [63:0]  last_id;
		logic [63:0]  prev_id;
		logic [63:0]  snap_id;
		logic [15:0]  tag;
		bit           hold;
	} feed_event_t;

	typedef struct packed {
		kind_t        kind;
		link_t        link;
		logic [63:0]  head_id;
		logic [63:0]  last_id;
		logic [63:0]  prev_id;
		logic [15:0]  tag;
		logic [31:0]  resyncs;
		logic         tlast;
	} seq_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [InDataPad-1:0]    s_tdata = '0;
	logic [InUserBits-1:0]   s_tuser = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [OutDataPad-1:0]   m_tdata;
	logic [OutUserBits-1:0]  m_tuser;
	logic                    m_tlast;

	feed_event_t  event_q[$];
	feed_event_t  cur_event;
	seq_result_t  awaited_results[$];
	int           mismatches = 0;
	int           xfer_in = 0;
	int           quiet_cycles = 0;

	// Shadow of the sequencer state.
	link_t        link_st = LK_DISC;
	logic [63:0]  buf_first[Depth];
	logic [63:0]  buf_last[Depth];
	logic [63:0]  buf_prev[Depth];
	logic [15:0]  buf_tag[Depth];
	int unsigned  buf_cnt = 0;
	logic [63:0]  snap_last = '0;
	logic [63:0]  applied_id = '0;
	logic [31:0]  resync_cnt = '0;

	// Generator bookkeeping for well-formed diff sequences.
	logic [63:0]  gen_cur;
	logic [63:0]  seq_first[$];
	logic [63:0]  seq_last[$];

	feed_snapshot_diff_sequencer_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic logic [63:0] rnd_id();
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick == 0) begin
			return '0;
		end else if (pick == 1) begin
			return '1;
		end
		return {$urandom, $urandom};
	endfunction

	function automatic logic [15:0] rnd_tag();
		return 16'($urandom_range(65535));
	endfunction

	// Percentage of cycles in which one side holds off, by phase of the run.
	function automatic int idle_pct(input bit rx);
		case ((xfer_in / 12) % 4)
			1: return rx ? 0 : 88;
			2: return rx ? 88 : 0;
			3: return 31;
			default: return 0;
		endcase
	endfunction

	task automatic add_ev(input cmd_t c, input logic [63:0] f, l, p, s,
			input logic [15:0] t, input bit hold);
		feed_event_t ev;
		ev.cmd = c;
		ev.head_id = f;
		ev.last_id = l;
		ev.prev_id = p;
		ev.snap_id = s;
		ev.tag = t;
		ev.hold = hold;
		event_q.insert(event_q.size(), ev);
	endtask

	// A diff that follows on from the previous one without a gap.
	task automatic add_diff(input int unsigned len);
		logic [63:0] f;
		logic [63:0] l;
		f = gen_cur + 64'd1;
		l = gen_cur + 64'(len);
		add_ev(CMD_DIFF, f, l, gen_cur, rnd_id(), rnd_tag(), 1'b0);
		seq_first.insert(seq_first.size(), f);
		seq_last.insert(seq_last.size(), l);
		gen_cur = l;
	endtask

	task automatic add_live_diff(input logic [63:0] snap);
		logic [63:0] f;
		logic [63:0] l;
		if ($urandom_range(99) < 20) begin
			f = snap + 64'd3;
		end else begin
			f = snap + 64'd1 - 64'($urandom_range(2));
		end
		l = snap + 64'($urandom_range(1, 4));
		add_ev(CMD_DIFF, f, l, rnd_id(), rnd_id(), rnd_tag(), 1'b0);
		gen_cur = l;
	endtask

	task automatic step_sequencer(input feed_event_t ev);
		seq_result_t  run[$];
		seq_result_t  r;
		int unsigned  i;
		int unsigned  cnt;
		int unsigned  hit;
		bit           found;
		logic [63:0]  nx;
		r = '0;
		hit = 0;
		found = 1'b0;
		case (ev.cmd)
			CMD_CONNECT: begin
				buf_cnt = 0;
				snap_last = '0;
				applied_id = '0;
				link_st = LK_BUF;
				r.kind = K_DONE;
				run.insert(run.size(), r);
			end
			CMD_DISCONNECT: begin
				buf_cnt = 0;
				link_st = LK_DISC;
				r.kind = K_DONE;
				run.insert(run.size(), r);
			end
			CMD_SNAPSHOT: begin
				if (link_st != LK_BUF && link_st != LK_AWAIT) begin
					r.kind = K_DROP;
					run.insert(run.size(), r);
				end else begin
					cnt = buf_cnt;
					snap_last = ev.snap_id;
					buf_cnt = 0;
					// Stale entries are those whose last id is not above the snapshot.
					for (i = 0; i < cnt; i++) begin
						if (!found && buf_last[i] > ev.snap_id) begin
							found = 1'b1;
							hit = i;
						end
					end
					nx = ev.snap_id + 64'd1;
					if (!found) begin
						link_st = LK_AWAIT;
						r.kind = K_DONE;
						run.insert(run.size(), r);
					end else if (buf_first[hit] <= nx && buf_last[hit] >= nx) begin
						for (i = hit; i < cnt; i++) begin
							if (buf_last[i] > ev.snap_id) begin
								r.kind = K_DRAIN;
								r.head_id = buf_first[i];
								r.last_id = buf_last[i];
								r.prev_id = buf_prev[i];
								r.tag = buf_tag[i];
								run.insert(run.size(), r);
								applied_id = buf_last[i];
							end
						end
						r = '0;
						link_st = LK_SYNC;
						r.kind = K_DONE;
						run.insert(run.size(), r);
					end else begin
						resync_cnt++;
						link_st = LK_RESYNC;
						r.kind = K_RESYNC;
						run.insert(run.size(), r);
					end
				end
			end
			default: begin
				nx = snap_last + 64'd1;
				case (link_st)
					LK_BUF: begin
						if (buf_cnt < Depth) begin
							buf_first[buf_cnt] = ev.head_id;
							buf_last[buf_cnt] = ev.last_id;
							buf_prev[buf_cnt] = ev.prev_id;
							buf_tag[buf_cnt] = ev.tag;
							buf_cnt++;
							r.kind = K_BUFFERED;
						end else begin
							r.kind = K_FULL;
						end
					end
					LK_AWAIT: begin
						if (ev.last_id <= snap_last) begin
							r.kind = K_DROP;
						end else if (ev.head_id <= nx && ev.last_id >= nx) begin
							applied_id = ev.last_id;
							link_st = LK_SYNC;
							r.kind = K_APPLY;
						end else begin
							resync_cnt++;
							link_st = LK_RESYNC;
							r.kind = K_RESYNC;
						end
					end
					LK_SYNC: begin
						if (ev.prev_id != applied_id) begin
							resync_cnt++;
							link_st = LK_RESYNC;
							r.kind = K_RESYNC;
						end else begin
							applied_id = ev.last_id;
							r.kind = K_APPLY;
						end
					end
					default: begin
						r.kind = K_DROP;
					end
				endcase
				if (r.kind == K_APPLY) begin
					r.head_id = ev.head_id;
					r.last_id = ev.last_id;
					r.prev_id = ev.prev_id;
					r.tag = ev.tag;
				end
				run.insert(run.size(), r);
			end
		endcase
		foreach (run[k]) begin
			run[k].link = link_st;
			run[k].resyncs = resync_cnt;
			run[k].tlast = (k == run.size() - 1);
			awaited_results.insert(awaited_results.size(), run[k]);
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// Driver: holds each event until its transfer, then moves to the next one.
	always @(posedge clk or negedge arst_n) begin
		bit busy;
		bit go;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				step_sequencer(cur_event);
				xfer_in++;
				busy = 1'b0;
			end
			if (!busy) begin
				go = event_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b0);
				if (go && event_q[0].hold && awaited_results.size() != 0) begin
					go = 1'b0;
				end
				if (go) begin
					cur_event = event_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= cur_event.cmd;
					s_tdata <= {cur_event.tag, cur_event.snap_id, cur_event.prev_id,
						cur_event.last_id, cur_event.head_id};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result transfer against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		seq_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					$display("%0t: result with none expected, kind %0d, tdata %0h, tlast %0b",
						$time, m_tuser, m_tdata, m_tlast);
				end else begin
					want = awaited_results.pop_front();
					check_field("kind", want.kind, m_tuser);
					check_field("seq_state", want.link, m_tdata[2:0]);
					check_field("first id", want.head_id, m_tdata[66:3]);
					check_field("last id", want.last_id, m_tdata[130:67]);
					check_field("prev id", want.prev_id, m_tdata[194:131]);
					check_field("tag", want.tag, m_tdata[210:195]);
					check_field("resync_total", want.resyncs, m_tdata[242:211]);
					check_field("last_of_run", want.tlast, m_tlast);
				end
			end
			m_tready <= $urandom_range(99) >= idle_pct(1'b1);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WdLimit) begin
			$display("%0t: no transfer for %0d cycles", $time, WdLimit);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [63:0]  snap;
		logic [63:0]  mx;
		int unsigned  k;
		int unsigned  j;
		int unsigned  r;

		mx = '1;
		// Directed part: every command in several link states, and corner cases.
		add_ev(CMD_DIFF, 64'd1, 64'd2, 64'd0, 64'd0, 16'h00aa, 1'b0);
		add_ev(CMD_SNAPSHOT, 64'd0, 64'd0, 64'd0, 64'd7, 16'h0000, 1'b0);
		add_ev(CMD_DISCONNECT, 64'd0, 64'd0, 64'd0, 64'd0, 16'h0000, 1'b0);
		add_ev(CMD_CONNECT, mx, mx, mx, mx, 16'hffff, 1'b0);
		add_ev(CMD_DIFF, 64'd0, 64'd0, 64'd0, 64'd0, 16'h0000, 1'b0);
		add_ev(CMD_DIFF, 64'd1, 64'd3, 64'd0, 64'd0, 16'hffff, 1'b0);
		add_ev(CMD_DIFF, 64'd4, 64'd5, 64'd3, 64'd0, 16'h1234, 1'b0);
		// The first entry is stale and skipped, the second spans the snapshot, and the second and third drain.
		add_ev(CMD_SNAPSHOT, 64'd0, 64'd0, 64'd0, 64'd0, 16'h0000, 1'b1);
		add_ev(CMD_DIFF, 64'd6, 64'd8, 64'd5, 64'd0, 16'h5a5a, 1'b0);
		add_ev(CMD_DIFF, 64'd9, 64'd9, 64'd7, 64'd0, 16'h0001, 1'b0);
		add_ev(CMD_DIFF, 64'd10, 64'd11, 64'd9, 64'd0, 16'h0002, 1'b0);
		add_ev(CMD_SNAPSHOT, 64'd0, 64'd0, 64'd0, 64'd50, 16'h0000, 1'b0);
		add_ev(CMD_CONNECT, 64'd0, 64'd0, 64'd0, 64'd0, 16'h0000, 1'b0);
		add_ev(CMD_SNAPSHOT, 64'd0, 64'd0, 64'd0, 64'd100, 16'h0000, 1'b0);
		add_ev(CMD_DIFF, 64'd90, 64'd100, 64'd89, 64'd0, 16'h0003, 1'b0);
		add_ev(CMD_DIFF, 64'd102, 64'd110, 64'd101, 64'd0, 16'h0004, 1'b0);
		add_ev(CMD_CONNECT, 64'd0, 64'd0, 64'd0, 64'd0, 16'h0000, 1'b0);
		add_ev(CMD_SNAPSHOT, 64'd0, 64'd0, 64'd0, 64'd100, 16'h0000, 1'b0);
		add_ev(CMD_DIFF, 64'd50, 64'd101, 64'd49, 64'd0, 16'h8000, 1'b0);
		add_ev(CMD_SNAPSHOT, 64'd0, 64'd0, 64'd0, 64'd200, 16'h0000, 1'b0);
		add_ev(CMD_CONNECT, 64'd0, 64'd0, 64'd0, 64'd0, 16'h0000, 1'b0);
		add_ev(CMD_DIFF, 64'd10, 64'd20, 64'd9, 64'd0, 16'h0005, 1'b0);
		// The surviving entry starts beyond the snapshot: a gap, so resync.
		add_ev(CMD_SNAPSHOT, 64'd0, 64'd0, 64'd0, 64'd5, 16'h0000, 1'b0);
		add_ev(CMD_CONNECT, 64'd0, 64'd0, 64'd0, 64'd0, 16'h0000, 1'b0);
		add_ev(CMD_DIFF, mx, mx, mx, mx, 16'hffff, 1'b0);
		add_ev(CMD_SNAPSHOT, 64'd0, 64'd0, 64'd0, mx, 16'h0000, 1'b0);
		add_ev(CMD_DIFF, mx, mx, mx, 64'd0, 16'hffff, 1'b0);
		add_ev(CMD_DISCONNECT, mx, mx, mx, mx, 16'hffff, 1'b0);

		// Fill the buffer past its depth, then drain every entry in one snapshot.
		seq_first.delete();
		seq_last.delete();
		gen_cur = {$urandom, $urandom};
		add_ev(CMD_CONNECT, rnd_id(), rnd_id(), rnd_id(), rnd_id(), rnd_tag(), 1'b1);
		repeat (Depth + 1) add_diff($urandom_range(1, 3));
		add_ev(CMD_SNAPSHOT, rnd_id(), rnd_id(), rnd_id(), seq_first[0] - 64'd1,
			rnd_tag(), 1'b0);
		gen_cur = seq_last[Depth - 1];
		repeat (3) add_diff($urandom_range(1, 3));

		while (event_q.size() < ItemGoal) begin
			r = $urandom_range(99);
			if (r < 70) begin
				seq_first.delete();
				seq_last.delete();
				gen_cur = rnd_id();
				add_ev(CMD_CONNECT, rnd_id(), rnd_id(), rnd_id(), rnd_id(), rnd_tag(),
					$urandom_range(99) < 5);
				k = $urandom_range(6);
				repeat (k) add_diff($urandom_range(1, 4));
				r = $urandom_range(99);
				if (k == 0) begin
					snap = gen_cur;
				end else if (r < 12) begin
					snap = seq_first[0] - 64'd2 - 64'($urandom_range(5));
				end else if (r < 20) begin
					snap = gen_cur + 64'($urandom_range(3));
				end else begin
					j = $urandom_range(k - 1);
					snap = seq_first[j] - 64'd1
						+ 64'($urandom_range(32'(seq_last[j] - seq_first[j])));
				end
				add_ev(CMD_SNAPSHOT, rnd_id(), rnd_id(), rnd_id(), snap, rnd_tag(), 1'b0);
				if (k == 0 || (r >= 12 && r < 20)) begin
					if ($urandom_range(99) < 40) begin
						add_ev(CMD_DIFF, snap - 64'd4, snap - 64'($urandom_range(3)),
							rnd_id(), rnd_id(), rnd_tag(), 1'b0);
					end
					add_live_diff(snap);
				end
				repeat ($urandom_range(5)) begin
					if ($urandom_range(99) < 10) begin
						add_ev(CMD_DIFF, gen_cur + 64'd1, gen_cur + 64'd2, gen_cur + 64'd1,
							rnd_id(), rnd_tag(), 1'b0);
					end else begin
						add_diff($urandom_range(1, 4));
					end
				end
				if ($urandom_range(99) < 25) begin
					add_ev(CMD_DISCONNECT, rnd_id(), rnd_id(), rnd_id(), rnd_id(), rnd_tag(),
						1'b0);
				end
			end else begin
				repeat ($urandom_range(1, 3)) begin
					add_ev(cmd_t'($urandom_range(3)), rnd_id(), rnd_id(), rnd_id(), rnd_id(),
						rnd_tag(), 1'b0);
				end
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (event_q.size() != 0 || s_tvalid || awaited_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/fsds_pkg.sv
src/fsds_ram.sv
src/fsds_cmp.sv
src/feed_snapshot_diff_sequencer_unit.sv
tb/tb_top.sv
